[rtl/core/msma_pkg.sv]
package msma_pkg;

  localparam int ByteW = 8;
  localparam int IdxW  = 6;
  localparam int ExpW  = 16;
  localparam int LenW  = 7;

  localparam logic [ByteW-1:0] StatSysex    = 8'hF0;
  localparam logic [ByteW-1:0] StatEox      = 8'hF7;
  localparam logic [ByteW-1:0] StatDebug    = 8'hFF;
  localparam logic [ByteW-1:0] StatVoiceMax = 8'hEF;
  localparam logic [ByteW-1:0] StatSysMax   = 8'hF7;
  localparam logic [ExpW-1:0]  SysexOpenLen = 16'hFFFF;

  typedef enum logic [1:0] {
    KindMidi  = 2'd0,
    KindDebug = 2'd1,
    KindStray = 2'd2
  } kind_e;

  // One word handed to the output stage.
  typedef struct packed {
    logic              load;
    logic              from_ram;
    logic [ByteW-1:0]  data;
    logic [IdxW-1:0]   idx;
    logic              last;
    kind_e             kind;
    logic              incomplete;
    logic              truncated;
  } out_load_t;

  // Number of data bytes that follow a status byte.
  function automatic logic [ExpW-1:0] data_length(input logic [ByteW-1:0] s);
    logic [3:0] hi;
    hi = s[7:4];
    if (hi == 4'hC || hi == 4'hD) return 16'd1;
    if (hi >= 4'h8 && hi <= 4'hE) return 16'd2;
    if (s == StatDebug) return 16'd3;
    if (s == StatSysex) return SysexOpenLen;
    if (s == 8'hF2) return 16'd2;
    if (s == 8'hF1 || s == 8'hF3) return 16'd1;
    return 16'd0;
  endfunction

endpackage

[rtl/core/msma_ram.sv]
module msma_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/msma_out.sv]
module msma_out
  import msma_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  out_load_t        load_i,
  input  logic [ByteW-1:0] ram_data_i,
  output logic             free_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [15:0]      m_tdata_o,
  output logic             m_tlast_o,
  output logic [3:0]       m_tuser_o
);

  logic      valid_q, valid_d;
  out_load_t meta_q, meta_d;
  logic [ByteW-1:0] data;

  // A new word may be loaded when the slot is empty or is taken this cycle.
  assign free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    meta_d  = meta_q;
    if (load_i.load) begin
      valid_d = 1'b1;
      meta_d  = load_i;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      meta_q  <= '0;
    end else begin
      valid_q <= valid_d;
      meta_q  <= meta_d;
    end
  end

  // Buffered bytes come straight from the RAM read register, which holds
  // while no read is issued.
  assign data       = meta_q.from_ram ? ram_data_i : meta_q.data;
  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {2'b00, meta_q.idx, data};
  assign m_tlast_o  = meta_q.last;
  assign m_tuser_o  = {meta_q.truncated, meta_q.incomplete, meta_q.kind};

endmodule

[rtl/core/midi_stream_message_assembler_top.sv]
// Channel  Dir  Signals                      Word contents (lowest bit first)
// s        in   s_tvalid_i/s_tready_o/tdata  rx_byte[7:0]
// m        out  m_tvalid_o/m_tready_i/tdata  msg_byte[7:0], byte_index[13:8], zero pad
//               m_tlast_o, m_tuser_o         last; kind[1:0], incomplete[2], truncated[3]
//
// A byte that completes or cuts off a message starts a drain of the message
// RAM, one word per cycle through its single read port while the output
// takes words; a cut then opens the new message in StStart, and a restart
// from running status appends its data byte in StPut.
// Reset clears all control state; the message RAM is not cleared.
// Input is held off while a message drains or a one-word result waits to load.
module midi_stream_message_assembler_top
  import msma_pkg::*;
#(
  parameter int MAX_MSG_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // rx_byte[7:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,   // msg_byte[7:0], byte_index[13:8]
  output logic        m_tlast_o,
  output logic [3:0]  m_tuser_o    // kind[1:0], incomplete[2], truncated[3]
);

  localparam int AddrW = $clog2(MAX_MSG_BYTES);
  localparam int CntW  = $clog2(MAX_MSG_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_MSG_BYTES);

  typedef enum logic [2:0] {
    StIdle,
    StDrain,
    StStart,
    StPut,
    StOne
  } state_e;

  state_e state_q, state_d;

  // Message bookkeeping. The first and fourth stored bytes are shadowed
  // here so the message kind and the debug text length need no RAM read.
  logic [CntW-1:0]  count_q, count_d;
  logic [ExpW-1:0]  exp_q, exp_d;
  logic [ByteW-1:0] run_q, run_d;
  logic             ovf_q, ovf_d;
  logic [ByteW-1:0] head_q, head_d;
  logic [LenW-1:0]  len_q, len_d;

  // Drain sequencer.
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic [AddrW-1:0] dr_last_q, dr_last_d;
  kind_e            dr_kind_q, dr_kind_d;
  logic             dr_inc_q, dr_inc_d;
  logic             dr_trunc_q, dr_trunc_d;
  logic             pend_start_q, pend_start_d;
  logic [ByteW-1:0] pend_q, pend_d;
  kind_e            one_kind_q, one_kind_d;

  // RAM port controls.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic             ram_re;
  logic [ByteW-1:0] ram_rdata;

  out_load_t        out_load;
  logic             out_free;

  logic             accept;
  logic [ByteW-1:0] in_b;

  // Put path: append one byte to the open message.
  logic [ByteW-1:0] put_b;
  logic             put_ok;
  logic [CntW-1:0]  put_cnt;
  logic [LenW-1:0]  put_len;
  logic [ExpW-1:0]  put_exp0;
  logic [ExpW-1:0]  put_exp;

  // Start path: open a new message with a status byte.
  logic [ByteW-1:0] start_b;
  logic [ExpW-1:0]  start_len;

  assign accept     = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == StIdle);
  assign in_b       = s_tdata_i;

  assign put_b    = (state_q == StPut) ? pend_q : in_b;
  assign put_ok   = (count_q < CntMax);
  assign put_cnt  = put_ok ? count_q + CntW'(1) : count_q;
  assign put_len  = (count_q == CntW'(3)) ? put_b[LenW-1:0] : len_q;
  assign put_exp0 = exp_q - 16'd1;
  // A debug header reloads the count from its fourth byte.
  assign put_exp  = (head_q == StatDebug && put_exp0 == '0 && put_cnt == CntW'(4))
                    ? ExpW'(put_len) : put_exp0;

  always_comb begin
    if (state_q == StStart) begin
      start_b = pend_q;
    end else if (in_b[7]) begin
      start_b = in_b;
    end else begin
      start_b = run_q;
    end
  end
  assign start_len = data_length(start_b);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    exp_d        = exp_q;
    run_d        = run_q;
    ovf_d        = ovf_q;
    head_d       = head_q;
    len_d        = len_q;
    rd_idx_d     = rd_idx_q;
    dr_last_d    = dr_last_q;
    dr_kind_d    = dr_kind_q;
    dr_inc_d     = dr_inc_q;
    dr_trunc_d   = dr_trunc_q;
    pend_start_d = pend_start_q;
    pend_d       = pend_q;
    one_kind_d   = one_kind_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AddrW-1:0];
    ram_wdata    = put_b;
    ram_re       = 1'b0;
    out_load     = '0;
    out_load.kind = KindMidi;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          pend_d = in_b;
          if (in_b[7]) begin
            if (in_b == StatEox && count_q != '0 && head_q == StatSysex) begin
              // End of SysEx: store the terminator and send the message whole.
              ram_we       = put_ok;
              ram_wdata    = in_b;
              state_d      = StDrain;
              rd_idx_d     = '0;
              dr_last_d    = AddrW'(put_cnt - CntW'(1));
              dr_kind_d    = (head_q == StatDebug) ? KindDebug : KindMidi;
              dr_inc_d     = 1'b0;
              dr_trunc_d   = ovf_q || !put_ok;
              pend_start_d = 1'b0;
              count_d      = '0;
              exp_d        = '0;
              ovf_d        = 1'b0;
            end else if (exp_q != '0) begin
              // A status byte cuts the open message short.
              state_d      = StDrain;
              rd_idx_d     = '0;
              dr_last_d    = AddrW'(count_q - CntW'(1));
              dr_kind_d    = (head_q == StatDebug) ? KindDebug : KindMidi;
              dr_inc_d     = 1'b1;
              dr_trunc_d   = ovf_q;
              pend_start_d = 1'b1;
              count_d      = '0;
              exp_d        = '0;
              ovf_d        = 1'b0;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = start_b;
              head_d    = start_b;
              exp_d     = start_len;
              ovf_d     = 1'b0;
              count_d   = CntW'(1);
              if (start_b <= StatVoiceMax) begin
                run_d = start_b;
              end else if (start_b <= StatSysMax) begin
                run_d = '0;
              end
              if (start_len == '0) begin
                // Single-byte message goes out directly.
                count_d    = '0;
                one_kind_d = KindMidi;
                state_d    = StOne;
              end
            end
          end else if (exp_q == '0 && run_q == '0) begin
            one_kind_d = KindStray;
            state_d    = StOne;
          end else if (exp_q == '0) begin
            // Running status: reopen with the saved status, then append.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = start_b;
            head_d    = start_b;
            exp_d     = start_len;
            ovf_d     = 1'b0;
            count_d   = CntW'(1);
            state_d   = StPut;
          end else begin
            ram_we  = put_ok;
            count_d = put_cnt;
            len_d   = put_len;
            ovf_d   = ovf_q || !put_ok;
            exp_d   = put_exp;
            if (put_exp == '0) begin
              state_d      = StDrain;
              rd_idx_d     = '0;
              dr_last_d    = AddrW'(put_cnt - CntW'(1));
              dr_kind_d    = (head_q == StatDebug) ? KindDebug : KindMidi;
              dr_inc_d     = 1'b0;
              dr_trunc_d   = ovf_q || !put_ok;
              pend_start_d = 1'b0;
              count_d      = '0;
              ovf_d        = 1'b0;
            end
          end
        end
      end

      StPut: begin
        ram_we  = put_ok;
        count_d = put_cnt;
        len_d   = put_len;
        ovf_d   = ovf_q || !put_ok;
        exp_d   = put_exp;
        state_d = StIdle;
        if (put_exp == '0) begin
          state_d      = StDrain;
          rd_idx_d     = '0;
          dr_last_d    = AddrW'(put_cnt - CntW'(1));
          dr_kind_d    = (head_q == StatDebug) ? KindDebug : KindMidi;
          dr_inc_d     = 1'b0;
          dr_trunc_d   = ovf_q || !put_ok;
          pend_start_d = 1'b0;
          count_d      = '0;
          ovf_d        = 1'b0;
        end
      end

      StStart: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = start_b;
        head_d    = start_b;
        exp_d     = start_len;
        ovf_d     = 1'b0;
        count_d   = CntW'(1);
        state_d   = StIdle;
        if (start_b <= StatVoiceMax) begin
          run_d = start_b;
        end else if (start_b <= StatSysMax) begin
          run_d = '0;
        end
        if (start_len == '0) begin
          count_d    = '0;
          one_kind_d = KindMidi;
          state_d    = StOne;
        end
      end

      StDrain: begin
        if (out_free) begin
          ram_re              = 1'b1;
          out_load.load       = 1'b1;
          out_load.from_ram   = 1'b1;
          out_load.idx        = IdxW'(rd_idx_q);
          out_load.last       = (rd_idx_q == dr_last_q);
          out_load.kind       = dr_kind_q;
          out_load.incomplete = dr_inc_q;
          out_load.truncated  = dr_trunc_q;
          if (rd_idx_q == dr_last_q) begin
            state_d = pend_start_q ? StStart : StIdle;
          end else begin
            rd_idx_d = rd_idx_q + AddrW'(1);
          end
        end
      end

      StOne: begin
        if (out_free) begin
          out_load.load = 1'b1;
          out_load.data = pend_q;
          out_load.last = 1'b1;
          out_load.kind = one_kind_q;
          state_d       = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      exp_q        <= '0;
      run_q        <= '0;
      ovf_q        <= 1'b0;
      head_q       <= '0;
      len_q        <= '0;
      rd_idx_q     <= '0;
      dr_last_q    <= '0;
      dr_kind_q    <= KindMidi;
      dr_inc_q     <= 1'b0;
      dr_trunc_q   <= 1'b0;
      pend_start_q <= 1'b0;
      pend_q       <= '0;
      one_kind_q   <= KindMidi;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      exp_q        <= exp_d;
      run_q        <= run_d;
      ovf_q        <= ovf_d;
      head_q       <= head_d;
      len_q        <= len_d;
      rd_idx_q     <= rd_idx_d;
      dr_last_q    <= dr_last_d;
      dr_kind_q    <= dr_kind_d;
      dr_inc_q     <= dr_inc_d;
      dr_trunc_q   <= dr_trunc_d;
      pend_start_q <= pend_start_d;
      pend_q       <= pend_d;
      one_kind_q   <= one_kind_d;
    end
  end

  msma_ram #(
    .Width(ByteW),
    .Depth(MAX_MSG_BYTES)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  msma_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .ram_data_i (ram_rdata),
    .free_o     (out_free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

[sim/midi_stream_message_assembler_checker.sv]
module midi_stream_message_assembler_checker
  import msma_pkg::*;
#(
  parameter int MAX_MSG_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // rx_byte[7:0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // msg_byte[7:0], byte_index[13:8]
  input  logic        m_tlast_i,
  input  logic [3:0]  m_tuser_i,   // kind[1:0], incomplete[2], truncated[3]
  input  logic        sweep_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  localparam logic [ByteW-1:0] StatMtcQuarter = 8'hF1;
  localparam logic [ByteW-1:0] StatSongPos    = 8'hF2;
  localparam logic [ByteW-1:0] StatSongSel    = 8'hF3;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [IdxW-1:0]  idx;
    logic             last;
    kind_e            kind;
    logic             incomplete;
    logic             truncated;
  } msg_word_t;

  msg_word_t        due_q[$];
  msg_word_t        head;
  logic [ByteW-1:0] msg_buf [MAX_MSG_BYTES];
  int unsigned      buf_cnt;
  logic [ExpW-1:0]  still_due;
  logic [ByteW-1:0] run_status;
  logic             overflowed;
  logic             swept;
  int               fail_cnt;
  int               word_cnt;

  function automatic logic [ExpW-1:0] payload_len(input logic [ByteW-1:0] s);
    if (s <= StatVoiceMax) return (s[6:5] == 2'b10) ? 16'd1 : 16'd2;
    case (s)
      StatDebug:                   return 16'd3;
      StatSysex:                   return SysexOpenLen;
      StatSongPos:                 return 16'd2;
      StatMtcQuarter, StatSongSel: return 16'd1;
      default:                     return '0;
    endcase
  endfunction

  function automatic void store_byte(input logic [ByteW-1:0] b);
    if (buf_cnt < MAX_MSG_BYTES) begin
      msg_buf[buf_cnt] = b;
      buf_cnt++;
    end else begin
      overflowed = 1'b1;
    end
  endfunction

  // Queues every stored byte of the open message and empties the buffer.
  function automatic void flush_msg(input logic cut);
    msg_word_t w;
    if (buf_cnt == 0) return;
    w.kind       = (msg_buf[0] == StatDebug) ? KindDebug : KindMidi;
    w.incomplete = cut;
    w.truncated  = overflowed;
    for (int unsigned i = 0; i < buf_cnt; i++) begin
      w.data = msg_buf[i];
      w.idx  = IdxW'(i);
      w.last = (i + 1 == buf_cnt);
      due_q.push_back(w);
    end
    buf_cnt    = 0;
    still_due  = '0;
    overflowed = 1'b0;
  endfunction

  function automatic void open_status(input logic [ByteW-1:0] b);
    if (b == StatEox && buf_cnt > 0 && msg_buf[0] == StatSysex) begin
      store_byte(b);
      flush_msg(1'b0);
      return;
    end
    if (still_due != 0) flush_msg(1'b1);
    if (b <= StatVoiceMax) run_status = b;
    else if (b <= StatSysMax) run_status = '0;
    still_due  = payload_len(b);
    buf_cnt    = 0;
    overflowed = 1'b0;
    store_byte(b);
  endfunction

  function automatic void predict_byte(input logic [ByteW-1:0] b);
    msg_word_t w;
    if (b[7]) begin
      open_status(b);
    end else begin
      if (still_due == 0 && run_status != 0) open_status(run_status);
      if (still_due == 0) begin
        w = '{data: b, idx: '0, last: 1'b1, kind: KindStray,
              incomplete: 1'b0, truncated: 1'b0};
        due_q.push_back(w);
        return;
      end
      store_byte(b);
      still_due = still_due - 1'b1;
      // A debug header's fourth byte gives the number of text bytes to come.
      if (msg_buf[0] == StatDebug && still_due == 0 && buf_cnt == 4)
        still_due = ExpW'(msg_buf[3]);
    end
    if (still_due == 0) flush_msg(1'b0);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q.delete();
      foreach (msg_buf[i]) msg_buf[i] = '0;
      buf_cnt    = 0;
      still_due  = '0;
      run_status = '0;
      overflowed = 1'b0;
      swept      = 1'b0;
      fail_cnt   = 0;
      word_cnt   = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) predict_byte(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (due_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected word, expected none, actual tdata 0x%0h tlast %0b tuser 0x%0h",
                   $time, m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          head = due_q.pop_front();
          word_cnt++;
          check_field("msg_byte", head.data, m_tdata_i[7:0]);
          check_field("byte_index", head.idx, m_tdata_i[13:8]);
          check_field("last", head.last, m_tlast_i);
          check_field("kind", head.kind, m_tuser_i[1:0]);
          check_field("incomplete", head.incomplete, m_tuser_i[2]);
          check_field("truncated", head.truncated, m_tuser_i[3]);
        end
      end
      if (sweep_i && !swept) begin
        swept = 1'b1;
        if (due_q.size() != 0) begin
          fail_cnt += due_q.size();
          $display("%0t: %0d expected words never arrived", $time, due_q.size());
        end
      end
    end
    errors_o  <= fail_cnt;
    checked_o <= word_cnt;
    pending_o <= due_q.size();
  end

endmodule

[sim/tb.sv]
module tb;
  import msma_pkg::*;

  localparam int MaxMsgBytes  = 32;
  localparam int CycleLimit   = 400000;
  localparam int PhaseItems   = 10;
  localparam int PressureItems = 8;
  localparam int HoldCycles   = 300;
  // A full buffer drains one word per cycle; leave room for that twice over.
  localparam int SettleCycles = 2 * MaxMsgBytes + 16;

  // Status bytes that the stimulus sends by name.
  localparam logic [7:0] StatVoiceMin   = 8'h80;
  localparam logic [7:0] StatNoteOn     = 8'h90;
  localparam logic [7:0] StatProgLast   = 8'hCF;
  localparam logic [7:0] StatMtcQuarter = 8'hF1;
  localparam logic [7:0] StatSongPos    = 8'hF2;
  localparam logic [7:0] StatSongSel    = 8'hF3;
  localparam logic [7:0] StatUndefF4    = 8'hF4;
  localparam logic [7:0] StatTuneReq    = 8'hF6;
  localparam logic [7:0] StatClock      = 8'hF8;
  localparam logic [7:0] StatActSense   = 8'hFE;
  localparam logic [7:0] DataMax        = 8'h7F;

  // Idle and stall percentages of the four random phases, in order: none,
  // sender gaps only, receiver stalls only, then both at a lighter rate.
  localparam int PhaseIdle  [4] = '{0, 59, 0, 23};
  localparam int PhaseStall [4] = '{0, 0, 59, 23};

  // Directed opening: each line exercises one corner of the byte parser.
  localparam logic [7:0] Directed [25] = '{
    StatNoteOn, 8'h3C, DataMax,           // a complete three-byte note-on
    8'h00, 8'h00,                         // lone data restarts from running status
    DataMax, StatClock,                   // a clock byte cuts the open message short
    8'h40, StatSysex, DataMax, StatEox,   // running status kept; sysex cuts, then closes
    8'h12,                                // sysex cleared running status, so a stray
    StatEox,                              // end-of-exclusive with no sysex open
    StatDebug, 8'h01, 8'h02, 8'h00,       // debug header announcing no text
    StatSongPos, 8'h00, DataMax,          // two-byte system common
    StatSongSel, 8'h01,                   // one-byte system common
    StatUndefF4,                          // system common with no data
    StatProgLast, DataMax                 // highest program-change status, one data byte
  };

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic [7:0]  s_tdata_i  = '0;
  logic        m_tready_i = 1'b0;
  logic        s_tready_o;
  logic        m_tvalid_o;
  logic [15:0] m_tdata_o;
  logic        m_tlast_o;
  logic [3:0]  m_tuser_o;

  logic sweep     = 1'b0;
  logic hold_kick = 1'b0;
  logic hold_seen = 1'b0;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  int   sent_cnt  = 0;
  int   cycle_cnt = 0;
  int   errors;
  int   pending;
  int   checked;

  midi_stream_message_assembler_top #(
    .MAX_MSG_BYTES(MaxMsgBytes)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o),
    .m_tuser_o (m_tuser_o)
  );

  // The checker sees both channels exactly as the block does and keeps its
  // own copy of the parser state to predict every output word.
  midi_stream_message_assembler_checker #(
    .MAX_MSG_BYTES(MaxMsgBytes)
  ) u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_i(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_i(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_i (m_tdata_o),
    .m_tlast_i (m_tlast_o),
    .m_tuser_i (m_tuser_o),
    .sweep_i   (sweep),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d words still expected",
               $time, cycle_cnt, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver. A toggle of hold_kick starts a long hold-off that this process
  // counts down on its own; otherwise tready follows the phase's stall rate.
  always @(posedge clk_i) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one word and returns at the edge that accepts it. Valid stays high
  // into the next call unless that call chooses to idle first.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  function automatic int unsigned voice_len(input logic [7:0] status);
    return (status[6:5] == 2'b10) ? 1 : 2;
  endfunction

  // Debug message: tag, two header bytes, the text length, then sent_len
  // text bytes. Sending fewer than announced leaves it open for a cut.
  task automatic send_debug(input int unsigned text_len, input int unsigned sent_len);
    send_byte(StatDebug);
    repeat (2) send_byte(8'($urandom_range(DataMax)));
    send_byte(8'(text_len));
    repeat (sent_len) send_byte(8'($urandom_range(DataMax)));
  endtask

  // One random sequence. Most are well formed with random content; a few are
  // broken messages or raw noise that land in every parser state.
  task automatic send_sequence();
    logic [7:0]  status;
    int unsigned n;
    case ($urandom_range(11))
      0, 1, 2: begin
        status = 8'($urandom_range(StatVoiceMin, StatVoiceMax));
        send_byte(status);
        repeat (voice_len(status)) send_byte(8'($urandom_range(DataMax)));
      end
      3: begin
        // Data only: running status restarts, or a stray when there is none.
        repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(DataMax)));
      end
      4: begin
        // Sysex, now and then longer than the buffer, sometimes left open.
        n = ($urandom_range(7) == 0) ? $urandom_range(MaxMsgBytes - 4, MaxMsgBytes + 8)
                                     : $urandom_range(6);
        send_byte(StatSysex);
        repeat (n) send_byte(8'($urandom_range(DataMax)));
        if ($urandom_range(5) != 0) send_byte(StatEox);
      end
      5: begin
        n = ($urandom_range(7) == 0) ? $urandom_range(MaxMsgBytes - 6, MaxMsgBytes + 8)
                                     : $urandom_range(5);
        send_debug(n, ($urandom_range(5) == 0) ? $urandom_range(n) : n);
      end
      6: begin
        status = 8'($urandom_range(StatMtcQuarter, StatTuneReq));
        send_byte(status);
        case (status)
          StatSongPos:                 n = 2;
          StatMtcQuarter, StatSongSel: n = 1;
          default:                     n = 0;
        endcase
        repeat (n) send_byte(8'($urandom_range(DataMax)));
      end
      7: send_byte(8'($urandom_range(StatClock, StatActSense)));
      8: begin
        // Voice message one data byte short.
        status = 8'($urandom_range(StatVoiceMin, StatVoiceMax));
        send_byte(status);
        repeat (voice_len(status) - 1) send_byte(8'($urandom_range(DataMax)));
      end
      default: send_byte(8'($urandom_range(255)));
    endcase
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Directed[i]) send_byte(Directed[i]);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = PhaseIdle[p];
      stall_pct = PhaseStall[p];
      phase_end = sent_cnt + PhaseItems;
      while (sent_cnt < phase_end) send_sequence();
    end

    // Back pressure: the receiver holds off while an over-long debug message
    // and more traffic keep coming, so the drain stalls and input backs up.
    idle_pct  = 0;
    stall_pct = 0;
    hold_kick <= ~hold_kick;
    send_debug(MaxMsgBytes + 4, MaxMsgBytes + 4);
    phase_end = sent_cnt + PressureItems;
    while (sent_cnt < phase_end) send_sequence();

    // A real-time byte closes whatever message is still open.
    send_byte(StatActSense);
    s_tvalid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    sweep <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Run covered %0d input words: directed parser corners, then well-formed, ",
             sent_cnt, "broken and noise streams under four idle and stall mixes.");
    $display("A %0d-cycle output hold-off backed up the input; %0d output words compared.",
             HoldCycles, checked);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
